@@ rtl/bbse_pkg.sv @@
// ----------------------------------------------------------------------------
// bbse_pkg
// Shared types and constants of the bicubic B-spline surface evaluator.
// ----------------------------------------------------------------------------
package bbse_pkg;

    localparam int PADDR_W    = 5;
    localparam int JOB_ADDR_W = 25;
    localparam int JOB_CELL_W = 13;
    localparam int LVL_W      = 4;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^26
    localparam logic [25:0] DIV3_MUL   = 26'd44739243;
    localparam int          DIV3_SHIFT = 27;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        REG_SCALE_X    = 3'd0,
        REG_OFFSET_X   = 3'd1,
        REG_SCALE_Y    = 3'd2,
        REG_OFFSET_Y   = 3'd3,
        REG_GRID_LEVEL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                  is_eval;
        logic [JOB_ADDR_W-1:0] addr;
        logic [31:0]           value;
        logic [JOB_CELL_W-1:0] cell_k;
        logic [JOB_CELL_W-1:0] cell_l;
        logic [15:0]           frac_s;
        logic [15:0]           frac_t;
        logic                  clamp;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAP,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SQ,
        B_CUBE,
        B_NUM,
        B_DIV,
        B_MAC,
        B_OUT
    } t_bstate;

endpackage

@@ rtl/bicubic_bspline_surface_eval.sv @@
// ----------------------------------------------------------------------------
// bicubic_bspline_surface_eval
// Uniform bicubic B-spline surface evaluator over a Q16.16 control lattice.
// ----------------------------------------------------------------------------
// After reset the block sweeps the (2^MAX_LEVEL+3)^2-entry lattice to zero,
// one entry a cycle, and holds busy high until done. An item is taken when
// start is high and busy is low; the front then stays busy while it maps the
// coordinates and hands the job to a two-entry queue, and for as long as that
// queue is full. The back writes a lattice entry in the same cycle that it
// pops the write; an evaluate takes basis weights, then sixteen reads of the
// single lattice read port through a four-stage multiply-accumulate pipe, and
// the back pops no new job until its result is out. Each result shows for one
// cycle with o_valid high and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module bicubic_bspline_surface_eval import bbse_pkg::*; #(
    parameter int MAX_LEVEL   = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic [COORD_WIDTH-1:0] i_x_coord,
    input  logic [COORD_WIDTH-1:0] i_y_coord,
    input  logic [6:0]             i_point_row,
    input  logic [6:0]             i_point_col,
    input  logic [31:0]            i_point_value,
    output logic                   o_valid,
    output logic [31:0]            o_surface_value,
    output logic                   o_clamped,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [31:0] r_scale_x, r_offset_x, r_scale_y, r_offset_y;
    logic [2:0]  r_grid_level;

    logic w_front_idle, w_push, w_pop, w_empty, w_full, w_clearing;
    t_job w_job_in, w_job_out;

    assign pready = 1'b1;
    assign busy   = !w_front_idle || w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x    <= 32'h0001_0000;
            r_offset_x   <= 32'h0000_0000;
            r_scale_y    <= 32'h0001_0000;
            r_offset_y   <= 32'h0000_0000;
            r_grid_level <= 3'd0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[PADDR_W-1:2]))
                REG_SCALE_X:    r_scale_x    <= pwdata;
                REG_OFFSET_X:   r_offset_x   <= pwdata;
                REG_SCALE_Y:    r_scale_y    <= pwdata;
                REG_OFFSET_Y:   r_offset_y   <= pwdata;
                REG_GRID_LEVEL: r_grid_level <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[PADDR_W-1:2]))
            REG_SCALE_X:    prdata = r_scale_x;
            REG_OFFSET_X:   prdata = r_offset_x;
            REG_SCALE_Y:    prdata = r_scale_y;
            REG_OFFSET_Y:   prdata = r_offset_y;
            REG_GRID_LEVEL: prdata = {29'd0, r_grid_level};
            default:        prdata = 32'd0;
        endcase
    end

    bbse_front #(
        .MAX_LEVEL   (MAX_LEVEL),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (start && !busy),
        .i_action      (i_action),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_point_row   (i_point_row),
        .i_point_col   (i_point_col),
        .i_point_value (i_point_value),
        .i_scale_x     (r_scale_x),
        .i_offset_x    (r_offset_x),
        .i_scale_y     (r_scale_y),
        .i_offset_y    (r_offset_y),
        .i_grid_level  (r_grid_level),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .o_idle        (w_front_idle)
    );

    bbse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    bbse_back #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_job           (w_job_out),
        .o_pop           (w_pop),
        .o_clearing      (w_clearing),
        .o_valid         (o_valid),
        .o_surface_value (o_surface_value),
        .o_clamped       (o_clamped)
    );

endmodule

@@ rtl/bbse_front.sv @@
// ----------------------------------------------------------------------------
// bbse_front
// Takes one item, maps evaluate coordinates to cell and fraction, turns
// lattice writes into an address, and pushes the job into the queue, dropping off-lattice writes.
// ----------------------------------------------------------------------------
module bbse_front import bbse_pkg::*; #(
    parameter int MAX_LEVEL   = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic                   i_action,
    input  logic [COORD_WIDTH-1:0] i_x_coord,
    input  logic [COORD_WIDTH-1:0] i_y_coord,
    input  logic [6:0]             i_point_row,
    input  logic [6:0]             i_point_col,
    input  logic [31:0]            i_point_value,
    input  logic [31:0]            i_scale_x,
    input  logic [31:0]            i_offset_x,
    input  logic [31:0]            i_scale_y,
    input  logic [31:0]            i_offset_y,
    input  logic [2:0]             i_grid_level,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_job                   o_job,
    output logic                   o_idle
);

    localparam int LAT   = 2**MAX_LEVEL + 3;
    localparam int DEPTH = LAT * LAT;
    localparam int AW    = $clog2(DEPTH);
    localparam int UW    = 33 + COORD_WIDTH;
    localparam int SW    = 17 + MAX_LEVEL;
    localparam int KW    = MAX_LEVEL + 1;

    t_fstate r_state, n_state;
    logic                          r_action;
    logic signed [COORD_WIDTH-1:0] r_x, r_y;
    logic [6:0]                    r_row, r_col;
    logic [31:0]                   r_value;
    logic signed [UW-1:0]          r_ux, r_uy;

    logic [LVL_W-1:0] w_lvl;
    logic [KW+16:0]   w_mx, w_my;
    logic             w_wr_ok;
    logic [AW-1:0]    w_addr;

    // {clamp, cell, fraction}
    function automatic logic [KW+16:0] map_axis(input logic signed [UW-1:0] u,
                                                input logic [LVL_W-1:0] lvl);
        logic          neg;
        logic          hi;
        logic [15:0]   u16;
        logic [SW-1:0] s;
        neg = u[UW-1];
        hi  = !neg && (u[UW-2:16] != '0);
        u16 = neg ? 16'h0000 : (hi ? 16'hFFFF : u[15:0]);
        s   = SW'(u16) << lvl;
        if (hi) begin
            s = {SW{1'b1}} >> (MAX_LEVEL + 1 - int'(lvl));
        end
        return {neg | hi, s[SW-1:16], s[15:0]};
    endfunction

    assign w_lvl   = (int'(i_grid_level) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL)
                                                      : LVL_W'(i_grid_level);
    assign w_mx    = map_axis(r_ux, w_lvl);
    assign w_my    = map_axis(r_uy, w_lvl);
    assign w_wr_ok = (int'(r_row) < LAT) && (int'(r_col) < LAT);
    assign w_addr  = AW'(r_row) * AW'(LAT) + AW'(r_col);

    always_comb begin
        o_job.is_eval = (r_action == ACTION_EVAL);
        o_job.addr    = JOB_ADDR_W'(w_addr);
        o_job.value   = r_value;
        o_job.cell_k  = JOB_CELL_W'(w_mx[KW+15:16]);
        o_job.cell_l  = JOB_CELL_W'(w_my[KW+15:16]);
        o_job.frac_s  = w_mx[15:0];
        o_job.frac_t  = w_my[15:0];
        o_job.clamp   = w_mx[KW+16] | w_my[KW+16];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_take) n_state = F_MAP;
            F_MAP:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_full || (r_action == ACTION_WRITE && !w_wr_ok)) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_idle = (r_state == F_IDLE);
        o_push = (r_state == F_PUSH) && !i_q_full
               && (r_action == ACTION_EVAL || w_wr_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_take) begin
            r_action <= i_action;
            r_x      <= i_x_coord;
            r_y      <= i_y_coord;
            r_row    <= i_point_row;
            r_col    <= i_point_col;
            r_value  <= i_point_value;
        end
        if (r_state == F_MAP) begin
            r_ux <= $signed(i_scale_x) * r_x + $signed(i_offset_x);
            r_uy <= $signed(i_scale_y) * r_y + $signed(i_offset_y);
        end
    end

endmodule

@@ rtl/bbse_queue.sv @@
// ----------------------------------------------------------------------------
// bbse_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module bbse_queue import bbse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_job   = r_slot[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_job;
    end

endmodule

@@ rtl/bbse_back.sv @@
// ----------------------------------------------------------------------------
// bbse_back
// Holds the control lattice, forms the basis weights of an evaluate job and
// accumulates the 4x4 weighted neighborhood through one memory read port.
// ----------------------------------------------------------------------------
module bbse_back import bbse_pkg::*; #(
    parameter int MAX_LEVEL = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    output logic [31:0] o_surface_value,
    output logic        o_clamped
);

    localparam int LAT   = 2**MAX_LEVEL + 3;
    localparam int DEPTH = LAT * LAT;
    localparam int AW    = $clog2(DEPTH);

    t_bstate r_state, n_state;

    logic signed [31:0] r_lat [DEPTH];
    logic signed [31:0] r_rd;

    logic [AW-1:0] r_clr;
    t_job          r_job;
    logic [15:0]   r_f  [2];
    logic [16:0]   r_v  [2];
    logic [31:0]   r_u2 [2];
    logic [33:0]   r_v2 [2];
    logic [47:0]   r_u3 [2];
    logic [48:0]   r_v3 [2];
    logic [25:0]   r_x  [2][4];
    logic [23:0]   r_w  [2][4];
    logic [AW-1:0] r_base;
    logic [4:0]    r_cnt;
    logic          r_p1, r_p2, r_p3;
    logic [47:0]   r_wp;
    logic [24:0]   r_w2;
    logic signed [31:0] r_dat;
    logic signed [57:0] r_prod;
    logic signed [63:0] r_acc;
    logic          r_o_valid;
    logic [31:0]   r_o_value;
    logic          r_o_clamp;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wd;
    logic          w_issue;
    logic [AW-1:0] w_ra;
    logic [1:0]    w_i, w_j;
    logic signed [40:0] w_round;
    logic [31:0]   w_sat;

    function automatic logic [51:0] basis_num(input logic [15:0] u,
                                              input logic [31:0] u2,
                                              input logic [47:0] u3,
                                              input logic [48:0] v3,
                                              input logic [1:0]  idx);
        logic [51:0] n;
        unique case (idx)
            2'd0: n = 52'(v3);
            2'd1: n = 52'(u3) * 52'd3 + (52'd4 << 48) - ((52'(u2) * 52'd6) << 16);
            2'd2: n = ((52'(u2) * 52'd3) << 16) + ((52'(u) * 52'd3) << 32)
                    + (52'd1 << 48) - 52'(u3) * 52'd3;
            default: n = 52'(u3);
        endcase
        return n;
    endfunction

    assign w_i = r_cnt[3:2];
    assign w_j = r_cnt[1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = B_IDLE;
            B_IDLE:  if (!i_empty && i_job.is_eval) n_state = B_SQ;
            B_SQ:    n_state = B_CUBE;
            B_CUBE:  n_state = B_NUM;
            B_NUM:   n_state = B_DIV;
            B_DIV:   n_state = B_MAC;
            B_MAC:   if (r_cnt == 5'd18) n_state = B_OUT;
            B_OUT:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == B_IDLE) && !i_empty;
        o_clearing = (r_state == B_CLEAR);
        w_issue    = (r_state == B_MAC) && !r_cnt[4];
        w_ra       = r_base + AW'(int'(w_i) * LAT) + AW'(w_j);
        if (r_state == B_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = 32'd0;
        end else begin
            w_we = o_pop && !i_job.is_eval;
            w_wa = i_job.addr[AW-1:0];
            w_wd = i_job.value;
        end
    end

    // floor((acc + half) / 2^24), then saturate
    assign w_round = 41'((r_acc + 64'sd8388608) >>> 24);
    always_comb begin
        if (w_round > 41'sd2147483647) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (w_round < -41'sd2147483648) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = w_round[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_lat[w_wa] <= w_wd;
        r_rd <= r_lat[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
            r_p3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p1      <= w_issue;
            r_p2      <= r_p1;
            r_p3      <= r_p2;
            r_o_valid <= (r_state == B_OUT);
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == B_MAC) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        unique case (r_state)
            B_SQ: begin
                r_f[0] <= r_job.frac_s;
                r_f[1] <= r_job.frac_t;
                r_v[0] <= 17'h10000 - 17'(r_job.frac_s);
                r_v[1] <= 17'h10000 - 17'(r_job.frac_t);
                r_u2[0] <= 32'(r_job.frac_s) * 32'(r_job.frac_s);
                r_u2[1] <= 32'(r_job.frac_t) * 32'(r_job.frac_t);
                r_v2[0] <= 34'(17'h10000 - 17'(r_job.frac_s))
                         * 34'(17'h10000 - 17'(r_job.frac_s));
                r_v2[1] <= 34'(17'h10000 - 17'(r_job.frac_t))
                         * 34'(17'h10000 - 17'(r_job.frac_t));
                r_base  <= AW'(r_job.cell_k) * AW'(LAT) + AW'(r_job.cell_l);
                r_acc   <= '0;
            end
            B_CUBE: begin
                for (int a = 0; a < 2; a++) begin
                    r_u3[a] <= 48'(r_u2[a]) * 48'(r_f[a]);
                    r_v3[a] <= 49'(51'(r_v2[a]) * 51'(r_v[a]));
                end
            end
            B_NUM: begin
                for (int a = 0; a < 2; a++) begin
                    for (int b = 0; b < 4; b++) begin
                        r_x[a][b] <= 26'((basis_num(r_f[a], r_u2[a], r_u3[a], r_v3[a],
                                                    2'(b)) + (52'd3 << 24)) >> 25);
                    end
                end
            end
            B_DIV: begin
                for (int a = 0; a < 2; a++) begin
                    for (int b = 0; b < 4; b++) begin
                        r_w[a][b] <= 24'((52'(r_x[a][b]) * 52'(DIV3_MUL)) >> DIV3_SHIFT);
                    end
                end
            end
            B_OUT: begin
                r_o_value <= w_sat;
                r_o_clamp <= r_job.clamp;
            end
            default: ;
        endcase
        // multiply-accumulate pipe: weight product, round, point product, sum
        r_wp   <= 48'(r_w[0][w_i]) * 48'(r_w[1][w_j]);
        r_w2   <= 25'((49'(r_wp) + 49'd8388608) >> 24);
        r_dat  <= r_rd;
        r_prod <= $signed({1'b0, r_w2}) * r_dat;
        if (r_p3) r_acc <= r_acc + 64'(r_prod);
    end

    assign o_valid         = r_o_valid;
    assign o_surface_value = r_o_value;
    assign o_clamped       = r_o_clamp;

endmodule

@@ rtl/bbse_checker.sv @@
// ----------------------------------------------------------------------------
// bbse_checker
// Port-level checks on the surface evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bbse_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic pready
);

    // the lattice sweep after reset holds off new items
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_result_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats back to back");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted item");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind bicubic_bspline_surface_eval bbse_checker u_bbse_checker (.*);
